[hdl/hapd_pkg.sv]
// Shared types, constants and helper functions of the hex-ASCII packet decoder.
`default_nettype none

package hapd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 12;

  localparam logic [7:0]  END_CHAR_RST = 8'h24;
  localparam logic [15:0] CRC_POLY_RST = 16'hA001;

  localparam logic [6:0] CHAR_SAT     = 7'd127;
  localparam logic [6:0] MIN_LEN      = 7'd11;
  localparam logic [6:0] TAIL_LEN     = 7'd4;
  localparam logic [6:0] HDR_NIBBLES  = 7'd6;
  // A legal length is 10 plus a multiple of 6, so its count modulo 6 is 4.
  localparam logic [2:0] LEN_MOD_OK   = 3'd4;
  localparam logic [2:0] MOD6_TOP     = 3'd5;
  localparam logic [1:0] VALUE_PHASE_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_CHAR = 2'd0,
    REG_CRC_POLY = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_SHORT    = 3'd1,
    STAT_BAD_LEN  = 3'd2,
    STAT_CRC      = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ
  } drain_state_e;

  typedef struct packed {
    logic       is_end;
    status_e    status;
    logic [7:0] sensor_id;
    logic [7:0] sensor_time;
    logic [7:0] packet_number;
  } pkt_info_t;

  function automatic logic [3:0] to_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v > 8'd64) begin
      v = v - 8'd7;
    end
    v = v - 8'd48;
    return v[3:0];
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] c,
                                           input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {8'h00, c};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/hapd_value_mem.sv]
// Synchronous value store: one write port, one read port with registered data.
`default_nettype none

module hapd_value_mem import hapd_pkg::*; #(
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  wire logic [SAMPLE_W-1:0] wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  output logic      [SAMPLE_W-1:0] rd_data_o
);

  logic [SAMPLE_W-1:0] mem_q [Depth];
  logic [SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[hdl/hapd_parser.sv]
// Character front end: delay line, CRC, header and value assembly, end-of-packet checks.
`default_nettype none

module hapd_parser import hapd_pkg::*; #(
  parameter int MaxValues = 32,
  localparam int AddrW = (MaxValues > 1) ? $clog2(MaxValues) : 1,
  localparam int VcntW = $clog2(MaxValues + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  byte_take_i,
  input  wire logic [7:0]            rx_byte_i,
  output pkt_info_t                  info_o,
  output logic      [VcntW-1:0]      value_count_o,
  output logic                       wr_en_o,
  output logic      [AddrW-1:0]      wr_addr_o,
  output logic      [SAMPLE_W-1:0]   wr_data_o
);

  localparam logic [VcntW-1:0] VcntMax = VcntW'(MaxValues);

  logic [7:0]          end_char_q;
  logic [15:0]         crc_poly_q;

  logic [6:0]          char_count_q, char_count_d;
  logic [2:0]          mod6_q, mod6_d;
  logic [7:0]          tail_q [4];
  logic [7:0]          tail_d [4];
  logic [15:0]         crc_q, crc_d;
  logic [7:0]          hdr_q [3];
  logic [7:0]          hdr_d [3];
  logic [SAMPLE_W-1:0] acc_q, acc_d;
  logic [1:0]          phase_q, phase_d;
  logic [VcntW-1:0]    vcnt_q, vcnt_d;
  logic                ovf_q, ovf_d;

  logic                is_end;
  logic [6:0]          pos;
  logic [3:0]          nib;
  logic [SAMPLE_W-1:0] acc_next;
  logic [15:0]         tail_crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char_q <= END_CHAR_RST;
      crc_poly_q <= CRC_POLY_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_END_CHAR: end_char_q <= cfg_wdata_i[7:0];
        REG_CRC_POLY: crc_poly_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign is_end   = (rx_byte_i == end_char_q);
  assign pos      = char_count_q - TAIL_LEN;
  assign nib      = to_nibble(tail_q[0]);
  assign acc_next = {acc_q[SAMPLE_W-5:0], nib};
  assign tail_crc = {to_nibble(tail_q[0]), to_nibble(tail_q[1]),
                     to_nibble(tail_q[2]), to_nibble(tail_q[3])};

  always_comb begin
    char_count_d = char_count_q;
    mod6_d       = mod6_q;
    tail_d       = tail_q;
    crc_d        = crc_q;
    hdr_d        = hdr_q;
    acc_d        = acc_q;
    phase_d      = phase_q;
    vcnt_d       = vcnt_q;
    ovf_d        = ovf_q;
    wr_en_o      = 1'b0;
    if (byte_take_i && is_end) begin
      // The packet is over whatever its status: start the next one clean.
      char_count_d = '0;
      mod6_d       = '0;
      tail_d       = '{default: '0};
      crc_d        = '0;
      hdr_d        = '{default: '0};
      acc_d        = '0;
      phase_d      = '0;
      vcnt_d       = '0;
      ovf_d        = 1'b0;
    end else if (byte_take_i) begin
      tail_d[0] = tail_q[1];
      tail_d[1] = tail_q[2];
      tail_d[2] = tail_q[3];
      tail_d[3] = rx_byte_i;
      if (char_count_q != CHAR_SAT) begin
        char_count_d = char_count_q + 7'd1;
        mod6_d       = (mod6_q == MOD6_TOP) ? 3'd0 : mod6_q + 3'd1;
      end
      if (char_count_q >= TAIL_LEN) begin
        crc_d = crc_byte(crc_q, tail_q[0], crc_poly_q);
        if (pos < HDR_NIBBLES) begin
          if (pos[0]) begin
            hdr_d[pos[2:1]] = {hdr_q[pos[2:1]][7:4], nib};
          end else begin
            hdr_d[pos[2:1]] = {nib, hdr_q[pos[2:1]][3:0]};
          end
        end else if (phase_q == VALUE_PHASE_LAST) begin
          acc_d   = '0;
          phase_d = '0;
          if (vcnt_q < VcntMax) begin
            wr_en_o = 1'b1;
            vcnt_d  = vcnt_q + VcntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          acc_d   = acc_next;
          phase_d = phase_q + 2'd1;
        end
      end
    end
  end

  assign wr_addr_o = vcnt_q[AddrW-1:0];
  assign wr_data_o = acc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      mod6_q       <= '0;
      tail_q       <= '{default: '0};
      crc_q        <= '0;
      hdr_q        <= '{default: '0};
      acc_q        <= '0;
      phase_q      <= '0;
      vcnt_q       <= '0;
      ovf_q        <= 1'b0;
    end else begin
      char_count_q <= char_count_d;
      mod6_q       <= mod6_d;
      tail_q       <= tail_d;
      crc_q        <= crc_d;
      hdr_q        <= hdr_d;
      acc_q        <= acc_d;
      phase_q      <= phase_d;
      vcnt_q       <= vcnt_d;
      ovf_q        <= ovf_d;
    end
  end

  always_comb begin
    info_o.is_end        = is_end;
    info_o.sensor_id     = hdr_q[0];
    info_o.sensor_time   = hdr_q[1];
    info_o.packet_number = hdr_q[2];
    if (char_count_q == CHAR_SAT) begin
      info_o.status = STAT_OVERFLOW;
    end else if (char_count_q < MIN_LEN) begin
      info_o.status = STAT_SHORT;
    end else if (mod6_q != LEN_MOD_OK) begin
      info_o.status = STAT_BAD_LEN;
    end else if (ovf_q) begin
      info_o.status = STAT_OVERFLOW;
    end else if (tail_crc != crc_q) begin
      info_o.status = STAT_CRC;
    end else begin
      info_o.status = STAT_OK;
    end
  end

  assign value_count_o = vcnt_q;

endmodule

`default_nettype wire

[hdl/hex_ascii_packet_decoder_crc16.sv]
// Hex-ASCII packet decoder with CRC-16 check: top level and result drain.
// A new byte may follow each cycle while the input is not stalled.
// An accepted end character loads its first result into the output register in the next cycle.
// Each value result, once the previous one is taken, is read from the store and then loaded.
// Input is stalled from the end character until its final result is taken.
// Reset clears control and packet state at once; the value store is not cleared.
`default_nettype none

module hex_ascii_packet_decoder_crc16 import hapd_pkg::*; #(
  parameter int MAX_VALUES = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             kind_o,
  output logic      [2:0]                  status_o,
  output logic      [7:0]                  sensor_id_o,
  output logic      [7:0]                  sensor_time_o,
  output logic      [7:0]                  packet_number_o,
  output logic signed [SAMPLE_W-1:0]       sample_value_o,
  output logic                             last_o
);

  localparam int AddrW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int VcntW = $clog2(MAX_VALUES + 1);

  drain_state_e        state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  status_e             status_q, status_d;
  logic [7:0]          id_q, id_d;
  logic [7:0]          tm_q, tm_d;
  logic [7:0]          pn_q, pn_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                last_q, last_d;
  logic [VcntW-1:0]    total_q, total_d;
  logic [VcntW-1:0]    rd_idx_q, rd_idx_d;

  logic                in_take;
  logic                out_take;
  logic                rd_en;
  pkt_info_t           info;
  logic [VcntW-1:0]    value_count;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [SAMPLE_W-1:0] rd_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  hapd_parser #(
    .MaxValues (MAX_VALUES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .byte_take_i   (in_take),
    .rx_byte_i     (rx_byte_i),
    .info_o        (info),
    .value_count_o (value_count),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  hapd_value_mem #(
    .Depth (MAX_VALUES)
  ) u_value_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    status_d    = status_q;
    id_d        = id_q;
    tm_d        = tm_q;
    pn_d        = pn_q;
    sample_d    = sample_q;
    last_d      = last_q;
    total_d     = total_q;
    rd_idx_d    = rd_idx_q;
    rd_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_take && info.is_end) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          status_d    = info.status;
          sample_d    = '0;
          rd_idx_d    = '0;
          state_d     = ST_EMIT;
          if (info.status == STAT_OK) begin
            id_d    = info.sensor_id;
            tm_d    = info.sensor_time;
            pn_d    = info.packet_number;
            last_d  = (value_count == '0);
            total_d = value_count;
          end else begin
            id_d    = '0;
            tm_d    = '0;
            pn_d    = '0;
            last_d  = 1'b1;
            total_d = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_take) begin
          out_valid_d = 1'b0;
          if (rd_idx_q != total_q) begin
            rd_en   = 1'b1;
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        kind_d      = 1'b1;
        status_d    = STAT_OK;
        id_d        = '0;
        tm_d        = '0;
        pn_d        = '0;
        sample_d    = rd_data;
        last_d      = (VcntW'(rd_idx_q + 1'b1) == total_q);
        rd_idx_d    = VcntW'(rd_idx_q + 1'b1);
        state_d     = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    id_q     <= id_d;
    tm_q     <= tm_d;
    pn_q     <= pn_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign sensor_id_o     = id_q;
  assign sensor_time_o   = tm_q;
  assign packet_number_o = pn_q;
  assign sample_value_o  = sample_q;
  assign last_o          = last_q;

  // No byte may enter while a result of the previous packet is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> !out_valid_q)
    else $error("byte accepted while a result is pending");

  // A store read is always followed by loading its value into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == ST_READ) && !out_valid_q)
    else $error("store read not followed by the load cycle");

  // Reads never go past the number of values captured for the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_idx_q < total_q))
    else $error("value read beyond the captured count");

  // Taking the final result of a packet returns the drain to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && last_q) |=> (state_q == ST_IDLE))
    else $error("drain did not finish after the final result");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the hex-ASCII packet decoder with CRC-16 check.
module tb;
  import hapd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int VALUE_DEPTH = 32;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_DROP, FLAW_EXTRA} flaw_e;

  typedef logic [11:0] value_list_t[$];

  typedef struct packed {
    logic       kind;
    status_e    status;
    logic [7:0] sensor_id;
    logic [7:0] sensor_time;
    logic [7:0] packet_number;
    logic [11:0] sample_value;
    logic       last;
  } sensor_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_END_CHAR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [2:0]            status;
  logic [7:0]            sensor_id;
  logic [7:0]            sensor_time;
  logic [7:0]            packet_number;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                  last;

  hex_ascii_packet_decoder_crc16 #(
    .MAX_VALUES(VALUE_DEPTH)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .status_o       (status),
    .sensor_id_o    (sensor_id),
    .sensor_time_o  (sensor_time),
    .packet_number_o(packet_number),
    .sample_value_o (sample_value),
    .last_o         (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and scoreboard bookkeeping.
  logic [7:0]      rx_backlog[$];
  int unsigned     bytes_in_flight = 0;
  sensor_result_t  expected_results[$];
  int unsigned     mismatch_count = 0;
  logic            in_taken = 1'b0;
  bit              gaps_on = 1'b1;
  int unsigned     alt_pct = 0;
  int unsigned     idle_left = 0;
  int unsigned     stall_left = 0;

  // Shadow copy of the decoder: configuration and per-packet state.
  logic [7:0]  end_char_now = END_CHAR_RST;
  logic [15:0] poly_now = CRC_POLY_RST;
  int unsigned char_total = 0;
  logic [7:0]  tail[4] = '{default: 8'h00};
  logic [15:0] crc_run = '0;
  logic [7:0]  hdr[3] = '{default: 8'h00};
  logic [11:0] accum = '0;
  int unsigned nib_phase = 0;
  int unsigned value_total = 0;
  logic [11:0] stored_values[VALUE_DEPTH];
  logic        overflowed = 1'b0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - ((c > 8'd64) ? 8'd55 : 8'd48);
    return d[3:0];
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] c,
                                           input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {8'h00, c};
    repeat (8) r = (r >> 1) ^ (r[0] ? poly : 16'h0000);
    return r;
  endfunction

  function automatic string fmt(input sensor_result_t r);
    return $sformatf("kind %0d status %0d id %02h time %02h pn %02h value %03h last %0d",
                     r.kind, r.status, r.sensor_id, r.sensor_time, r.packet_number,
                     r.sample_value, r.last);
  endfunction

  task automatic decode_rx_byte(input logic [7:0] c);
    logic [7:0]     oldest;
    logic [3:0]     n;
    logic [15:0]    crc_rx;
    int unsigned    pos;
    status_e        st;
    sensor_result_t r;
    if (c != end_char_now) begin
      oldest = tail[0];
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = tail[3];
      tail[3] = c;
      if (char_total >= 4) begin
        pos = char_total - 4;
        n = nibble_of(oldest);
        crc_run = crc_step(crc_run, oldest, poly_now);
        if (pos < 6) begin
          if (pos % 2 == 1) hdr[pos / 2][3:0] = n;
          else hdr[pos / 2][7:4] = n;
        end else begin
          accum = {accum[7:0], n};
          if (nib_phase == 2) begin
            if (value_total < VALUE_DEPTH) begin
              stored_values[value_total] = accum;
              value_total++;
            end else begin
              overflowed = 1'b1;
            end
            accum = '0;
            nib_phase = 0;
          end else begin
            nib_phase++;
          end
        end
      end
      if (char_total < 127) char_total++;
    end else begin
      crc_rx = {nibble_of(tail[0]), nibble_of(tail[1]), nibble_of(tail[2]), nibble_of(tail[3])};
      if (char_total >= 127) st = STAT_OVERFLOW;
      else if (char_total < 11) st = STAT_SHORT;
      else if ((char_total - 10) % 6 != 0) st = STAT_BAD_LEN;
      else if (overflowed) st = STAT_OVERFLOW;
      else if (crc_rx != crc_run) st = STAT_CRC;
      else st = STAT_OK;
      r = '0;
      r.kind = KIND_HEADER;
      r.status = st;
      if (st != STAT_OK) begin
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        r.sensor_id = hdr[0];
        r.sensor_time = hdr[1];
        r.packet_number = hdr[2];
        r.last = (value_total == 0);
        expected_results.push_back(r);
        for (int i = 0; i < value_total; i++) begin
          r = '0;
          r.kind = KIND_VALUE;
          r.sample_value = stored_values[i];
          r.last = (i + 1 == value_total);
          expected_results.push_back(r);
        end
      end
      char_total = 0;
      tail = '{default: 8'h00};
      crc_run = '0;
      hdr = '{default: 8'h00};
      accum = '0;
      nib_phase = 0;
      value_total = 0;
      overflowed = 1'b0;
    end
  endtask

  // Input channel: a byte stays on the bus until it is taken.
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // Hold the current transaction.
    end else if (idle_left > 0) begin
      idle_left--;
      in_valid <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      idle_left = $urandom_range(0, 11);
      in_valid <= 1'b0;
    end else if (rx_backlog.size() != 0) begin
      in_valid <= 1'b1;
      rx_byte <= rx_backlog.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Prediction on each accepted byte, comparison on each accepted result.
  always @(posedge clk) begin
    sensor_result_t got;
    sensor_result_t want;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        decode_rx_byte(rx_byte);
        bytes_in_flight--;
      end
      if (out_valid && !out_stall) begin
        got.kind = kind;
        got.status = status_e'(status);
        got.sensor_id = sensor_id;
        got.sensor_time = sensor_time;
        got.packet_number = packet_number;
        got.sample_value = sample_value;
        got.last = last;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result: %s", fmt(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected %s", fmt(want));
              $display("          actual   %s", fmt(got));
            end
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_in_flight++;
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == end_char_now);
    return c;
  endfunction

  // Picks a character that decodes to nibble n; the odd spellings are control codes,
  // punctuation, letters and high bytes that decode to the same nibble.
  function automatic logic [7:0] char_for(input logic [3:0] n);
    logic [7:0] c;
    c = (n < 10) ? 8'h30 + n : 8'h37 + n;
    if (c == end_char_now || $urandom_range(0, 99) < alt_pct) begin
      do begin
        if ($urandom_range(0, 1) == 1) c = {4'($urandom_range(0, 3)), n};
        else c = {4'($urandom_range(5, 15)), n + 4'd7};
      end while (c == end_char_now);
    end
    return c;
  endfunction

  function automatic value_list_t random_values(input int count);
    value_list_t vals;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: vals.push_back(12'h7FF);
        1: vals.push_back(12'h800);
        default: vals.push_back(12'($urandom_range(0, 4095)));
      endcase
    end
    return vals;
  endfunction

  task automatic send_packet(input logic [7:0] id, input logic [7:0] tm, input logic [7:0] pn,
                             input value_list_t vals, input flaw_e flaw);
    logic [7:0]  line[$];
    logic [15:0] sum;
    logic [23:0] head;
    head = {id, tm, pn};
    for (int i = 5; i >= 0; i--) line.push_back(char_for(head[4*i +: 4]));
    foreach (vals[i]) begin
      for (int k = 2; k >= 0; k--) line.push_back(char_for(vals[i][4*k +: 4]));
    end
    sum = '0;
    foreach (line[i]) sum = crc_step(sum, line[i], poly_now);
    if (flaw == FLAW_CRC) sum ^= 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
    for (int k = 3; k >= 0; k--) line.push_back(char_for(sum[4*k +: 4]));
    if (flaw == FLAW_DROP) line.delete($urandom_range(0, line.size() - 1));
    if (flaw == FLAW_EXTRA) line.insert($urandom_range(0, line.size()), stray_byte());
    foreach (line[i]) queue_byte(line[i]);
    queue_byte(end_char_now);
  endtask

  task automatic send_chars(input int count, input bit noisy);
    repeat (count) queue_byte(noisy ? stray_byte() : char_for(4'($urandom_range(0, 15))));
    queue_byte(end_char_now);
  endtask

  task automatic random_traffic(input int packets);
    int    pick;
    int    nv;
    flaw_e flaw;
    repeat (packets) begin
      pick = $urandom_range(0, 99);
      nv = 2 * $urandom_range(1, 2);
      flaw = FLAW_NONE;
      if (pick >= 95) begin
        send_chars($urandom_range(0, 24), 1'b1);
      end else begin
        if (pick >= 90) nv--;
        else if (pick >= 82) flaw = FLAW_EXTRA;
        else if (pick >= 74) flaw = FLAW_DROP;
        else if (pick >= 64) flaw = FLAW_CRC;
        send_packet(8'($urandom), 8'($urandom), 8'($urandom), random_values(nv), flaw);
      end
    end
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_END_CHAR: end_char_now = data[7:0];
      REG_CRC_POLY: poly_now = data;
      default: ;
    endcase
  endtask

  // The decoder drains its results before it takes the next byte, so a closing
  // wait after the last result covers any trailing work.
  task automatic wait_idle();
    do @(negedge clk); while (bytes_in_flight != 0 || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed packets under the reset configuration.
    send_packet(8'hFF, 8'hFF, 8'hFF, '{12'h7FF, 12'h800, 12'h001, 12'hFFE}, FLAW_NONE);
    send_chars(0, 1'b0);
    send_chars(10, 1'b0);
    send_chars(11, 1'b1);
    send_packet(8'h12, 8'h34, 8'h56, '{12'h000, 12'hFFF}, FLAW_CRC);
    alt_pct = 100;
    send_packet(8'hA5, 8'h5A, 8'hC3, '{12'hABC, 12'hDEF}, FLAW_NONE);
    alt_pct = 0;
    wait_idle();

    set_register(REG_END_CHAR, 16'h0000);
    set_register(REG_CRC_POLY, 16'h0000);
    set_register(REG_SPARE, 16'($urandom));
    alt_pct = 20;
    random_traffic(1);
    wait_idle();

    set_register(REG_END_CHAR, 16'($urandom_range(0, 255)));
    set_register(REG_CRC_POLY, 16'($urandom));
    alt_pct = $urandom_range(0, 40);
    random_traffic(1);
    wait_idle();

    // A closing stretch with both sides running flat out.
    gaps_on = 1'b0;
    set_register(REG_END_CHAR, 16'h000A);
    set_register(REG_CRC_POLY, 16'h8408);
    alt_pct = 10;
    random_traffic(1);
    wait_idle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("simulation failed");
    $finish;
  end

endmodule
